/* src/ahs_pkg.sv */
package ahs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_SEEK       = 3'd1,
		PH_BACKOFF    = 3'd2,
		PH_LATCH      = 3'd3,
		PH_SERVO_SEEK = 3'd4,
		PH_SERVO_CONF = 3'd5,
		PH_DONE       = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_VEL   = 3'd1,
		CMD_REL   = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_HOMED = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_AXIS_KIND      = 3'd0,
		REG_SEEK_VELOCITY  = 3'd1,
		REG_LATCH_VELOCITY = 3'd2,
		REG_BACKOFF        = 3'd3,
		REG_SEEK_DIRECTION = 3'd4,
		REG_ENDSTOP_POL    = 3'd5
	} cfg_idx_t;

	localparam logic [1:0] KIND_STEPPER = 2'd1;
	localparam logic [1:0] KIND_SERVO   = 2'd2;

	localparam logic ACT_START = 1'b0;

	localparam logic [1:0] DIR_ZERO = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;

	localparam logic [1:0]         AXIS_KIND_RST      = KIND_STEPPER;
	localparam logic [30:0]        SEEK_VELOCITY_RST  = 31'd5000;
	localparam logic [30:0]        LATCH_VELOCITY_RST = 31'd500;
	localparam logic signed [31:0] BACKOFF_RST        = 32'sd200;
	localparam logic signed [1:0]  SEEK_DIRECTION_RST = -2'sd1;
	localparam logic               ENDSTOP_POL_RST    = 1'b0;

	typedef struct packed {
		logic [1:0]         axis_kind;
		logic [30:0]        seek_velocity;
		logic [30:0]        latch_velocity;
		logic signed [31:0] backoff_distance;
		logic signed [1:0]  seek_direction;
		logic               endstop_active_high;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [31:0] request_seq;
		logic        endstop_level;
		logic        endstop_ready;
		logic        steps_done;
		logic        feedback_high;
	} item_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] amount;
		logic [31:0]        event_seq;
		logic               homed_flag;
		logic               busy_flag;
		phase_t             phase_out;
	} result_t;

endpackage

/* src/ahs_ifs.sv */
interface ahs_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] request_seq;
	logic        endstop_level;
	logic        endstop_ready;
	logic        steps_done;
	logic        feedback_high;

	modport source (
		output valid, action, request_seq, endstop_level, endstop_ready, steps_done,
			feedback_high,
		input  ready
	);
	modport sink (
		input  valid, action, request_seq, endstop_level, endstop_ready, steps_done,
			feedback_high,
		output ready
	);
endinterface

interface ahs_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [31:0] amount;
	logic [31:0]        event_seq;
	logic               homed_flag;
	logic               busy_flag;
	logic [2:0]         phase_out;

	modport source (
		output valid, command, amount, event_seq, homed_flag, busy_flag, phase_out,
		input  ready
	);
	modport sink (
		input  valid, command, amount, event_seq, homed_flag, busy_flag, phase_out,
		output ready
	);
endinterface

/* src/axis_homing_sequencer.sv */
// Channel   Direction  Handshake       Payload
// item      sink       valid / ready   action, request_seq, endstop and feedback levels
// result    source     valid / ready   command, amount, event_seq, flags, phase_out
// cfg       write only cfg_we          cfg_index, cfg_wdata
//
// One item is taken per cycle while the result side is not stalled; the item is held in the
// item register and its result then in the result register, from which the result transfers.
// The item register feeds the state update, which is applied as the result is registered.
// A stalled result holds the result register; the item register keeps accepting while it is
// empty or the result register is free or being drained in the same cycle.
// Reset returns the phase to idle, clears busy, homed and the saved sequence number,
// and loads the default register values.
module axis_homing_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	ahs_in_if.sink                         item,
	ahs_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [ahs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	ahs_pkg::cfg_t    cfg;
	ahs_pkg::item_t   item_s1;
	logic             item_v_s1;
	ahs_pkg::result_t core_res;
	ahs_pkg::result_t res_s2;
	logic             res_v_s2;
	logic             adv_s2;
	logic             fire;

	assign adv_s2     = !res_v_s2 || result.ready;
	assign fire       = item_v_s1 && adv_s2;
	assign item.ready = !item_v_s1 || adv_s2;

	ahs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ahs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			res_v_s2  <= 1'b0;
		end else begin
			if (item.ready) begin
				item_v_s1 <= item.valid;
			end
			if (adv_s2) begin
				res_v_s2 <= item_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action        <= item.action;
			item_s1.request_seq   <= item.request_seq;
			item_s1.endstop_level <= item.endstop_level;
			item_s1.endstop_ready <= item.endstop_ready;
			item_s1.steps_done    <= item.steps_done;
			item_s1.feedback_high <= item.feedback_high;
		end
		if (fire) begin
			res_s2 <= core_res;
		end
	end

	assign result.valid      = res_v_s2;
	assign result.command    = res_s2.command;
	assign result.amount     = res_s2.amount;
	assign result.event_seq  = res_s2.event_seq;
	assign result.homed_flag = res_s2.homed_flag;
	assign result.busy_flag  = res_s2.busy_flag;
	assign result.phase_out  = res_s2.phase_out;

	// Homing can never be both in progress and finished.
	a_busy_homed_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.busy_flag && result.homed_flag))
		else $error("busy and homed reported together");

	// A homed report always lands in the complete phase with homed set.
	a_homed_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.command == ahs_pkg::CMD_HOMED) |->
		(result.phase_out == ahs_pkg::PH_DONE && result.homed_flag))
		else $error("homed command outside the complete phase");

	// Only velocity and relative-move commands carry an amount.
	a_amount_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.command != ahs_pkg::CMD_VEL &&
		 result.command != ahs_pkg::CMD_REL) |-> result.amount == 32'sd0)
		else $error("nonzero amount on a command without one");

	// A held item is not lost while the result side is stalled.
	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(item_v_s1 && !adv_s2) |=> item_v_s1)
		else $error("item register dropped during a stall");

endmodule

/* src/ahs_cfg_regs.sv */
module ahs_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ahs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ahs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output ahs_pkg::cfg_t                   cfg
);

	ahs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_kind           <= ahs_pkg::AXIS_KIND_RST;
			cfg_q.seek_velocity       <= ahs_pkg::SEEK_VELOCITY_RST;
			cfg_q.latch_velocity      <= ahs_pkg::LATCH_VELOCITY_RST;
			cfg_q.backoff_distance    <= ahs_pkg::BACKOFF_RST;
			cfg_q.seek_direction      <= ahs_pkg::SEEK_DIRECTION_RST;
			cfg_q.endstop_active_high <= ahs_pkg::ENDSTOP_POL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ahs_pkg::REG_AXIS_KIND:      cfg_q.axis_kind        <= cfg_wdata[1:0];
				ahs_pkg::REG_SEEK_VELOCITY:  cfg_q.seek_velocity    <= cfg_wdata[30:0];
				ahs_pkg::REG_LATCH_VELOCITY: cfg_q.latch_velocity   <= cfg_wdata[30:0];
				ahs_pkg::REG_BACKOFF:        cfg_q.backoff_distance <= $signed(cfg_wdata);
				ahs_pkg::REG_SEEK_DIRECTION: cfg_q.seek_direction   <= $signed(cfg_wdata[1:0]);
				ahs_pkg::REG_ENDSTOP_POL:    cfg_q.endstop_active_high <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/ahs_core.sv */
module ahs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  ahs_pkg::cfg_t    cfg,
	input  ahs_pkg::item_t   item,
	output ahs_pkg::result_t res
);

	ahs_pkg::phase_t    phase_q, phase_nxt;
	logic               busy_q, busy_nxt;
	logic               homed_q, homed_nxt;
	logic [31:0]        seq_q, seq_nxt;
	ahs_pkg::cmd_t      cmd;
	logic signed [31:0] amt;
	logic signed [31:0] servo_vel;
	logic               trig;

	always_comb begin
		if (cfg.seek_direction == ahs_pkg::DIR_ZERO) begin
			servo_vel = '0;
		end else if (cfg.seek_direction == ahs_pkg::DIR_POS) begin
			servo_vel = $signed({1'b0, cfg.seek_velocity});
		end else begin
			servo_vel = 32'sd0 - $signed({1'b0, cfg.seek_velocity});
		end
	end

	assign trig = (item.endstop_level == cfg.endstop_active_high);

	always_comb begin
		phase_nxt = phase_q;
		busy_nxt  = busy_q;
		homed_nxt = homed_q;
		seq_nxt   = seq_q;
		cmd       = ahs_pkg::CMD_NONE;
		amt       = '0;
		if (item.action == ahs_pkg::ACT_START) begin
			// An unconfigured kind still marks the axis busy but issues nothing.
			busy_nxt  = 1'b1;
			homed_nxt = 1'b0;
			seq_nxt   = item.request_seq;
			if (cfg.axis_kind == ahs_pkg::KIND_STEPPER) begin
				phase_nxt = ahs_pkg::PH_SEEK;
				cmd       = ahs_pkg::CMD_VEL;
				amt       = 32'sd0 - $signed({1'b0, cfg.seek_velocity});
			end else if (cfg.axis_kind == ahs_pkg::KIND_SERVO) begin
				phase_nxt = ahs_pkg::PH_SERVO_SEEK;
				cmd       = ahs_pkg::CMD_VEL;
				amt       = servo_vel;
			end
		end else if (cfg.axis_kind == ahs_pkg::KIND_STEPPER) begin
			if (item.endstop_ready) begin
				case (phase_q)
					ahs_pkg::PH_SEEK: begin
						if (trig) begin
							phase_nxt = ahs_pkg::PH_BACKOFF;
							cmd       = ahs_pkg::CMD_REL;
							amt       = cfg.backoff_distance;
						end
					end
					ahs_pkg::PH_BACKOFF: begin
						if (item.steps_done) begin
							phase_nxt = ahs_pkg::PH_LATCH;
							cmd       = ahs_pkg::CMD_VEL;
							amt       = 32'sd0 - $signed({1'b0, cfg.latch_velocity});
						end
					end
					ahs_pkg::PH_LATCH: begin
						if (trig) begin
							phase_nxt = ahs_pkg::PH_DONE;
							busy_nxt  = 1'b0;
							homed_nxt = 1'b1;
							cmd       = ahs_pkg::CMD_HOMED;
						end
					end
					default: ;
				endcase
			end
		end else if (cfg.axis_kind == ahs_pkg::KIND_SERVO) begin
			case (phase_q)
				ahs_pkg::PH_SERVO_SEEK: begin
					if (!item.feedback_high) begin
						phase_nxt = ahs_pkg::PH_SERVO_CONF;
						cmd       = ahs_pkg::CMD_STOP;
					end
				end
				ahs_pkg::PH_SERVO_CONF: begin
					phase_nxt = ahs_pkg::PH_DONE;
					busy_nxt  = 1'b0;
					homed_nxt = 1'b1;
					cmd       = ahs_pkg::CMD_HOMED;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ahs_pkg::PH_IDLE;
			busy_q  <= 1'b0;
			homed_q <= 1'b0;
			seq_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			busy_q  <= busy_nxt;
			homed_q <= homed_nxt;
			seq_q   <= seq_nxt;
		end
	end

	always_comb begin
		res.command    = cmd;
		res.amount     = amt;
		res.event_seq  = seq_nxt;
		res.homed_flag = homed_nxt;
		res.busy_flag  = busy_nxt;
		res.phase_out  = phase_nxt;
	end

endmodule
